// ===== rtl/ktp_pkg.sv =====
// shared codes for the keyed time table predictor
// action and status codes plus the sequencer state type; no dependencies
package ktp_pkg;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_HIT      = 3'd1;
   localparam logic [2:0] ST_SCALED   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   localparam int PRED_BITS = 48;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN1 = 6'b000010,
      S_SCAN2 = 6'b000100,
      S_MUL   = 6'b001000,
      S_DIV   = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

endpackage

// ===== rtl/keyed_time_table_predictor_core.sv =====
// keyed time table predictor: entry table memory, scan sequencer, serial
// multiplier and restoring divider; depends on ktp_pkg
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | action, tile_size, trans_a/b, entry_time
//  rsp     | out       | rsp_valid/rsp_stall | status, predicted_time, smallest/largest_size
//
// clear, append and no-op items go straight to the finish state; a query takes up to two
// passes over the stored entries, then the serial multiplier and the restoring divider;
// the single-port table memory and the one-bit-per-cycle divider set the pace of a query
// synchronous active-high reset empties the table; entry contents are not cleared
// one item is in work at a time; a finished result sits in the output register
// so the next item is taken while rsp_stall holds it
module keyed_time_table_predictor_core #(
   parameter int TABLE_DEPTH = 256,
   parameter int SIZE_BITS   = 14,
   parameter int TIME_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic [SIZE_BITS-1:0]          req_tile_size,
   input  logic [7:0]                    req_trans_a,
   input  logic [7:0]                    req_trans_b,
   input  logic [TIME_BITS-1:0]          req_entry_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [ktp_pkg::PRED_BITS-1:0] rsp_predicted_time,
   output logic [SIZE_BITS-1:0]          rsp_smallest_size,
   output logic [SIZE_BITS-1:0]          rsp_largest_size
);
   import ktp_pkg::*;

   localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int CW   = 3 * SIZE_BITS;
   localparam int NW   = TIME_BITS + CW;
   localparam int QW   = (NW > PRED_BITS) ? NW : PRED_BITS;
   localparam int DCW  = $clog2(NW + 1);

   typedef struct packed {
      logic [SIZE_BITS-1:0] size;
      logic [7:0]           code_a;
      logic [7:0]           code_b;
      logic [TIME_BITS-1:0] etime;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rdata_ff;

   state_type            state_ff, state_in;
   logic [CNTW-1:0]      count_ff, idx_ff, pend_idx_ff;
   logic                 pend_ff, nstop_ff;
   logic [SIZE_BITS-1:0] min_ff, max_ff;
   logic [2:0]           mstep_ff;
   logic [DCW-1:0]       dcnt_ff;
   logic [SIZE_BITS-1:0] q_ff, near_ff;
   logic [7:0]           ca_ff, cb_ff;
   logic [TIME_BITS-1:0] t_ff;
   logic [CW-1:0]        n_ff, d_ff, rem_ff;
   logic [NW-1:0]        mul_a_ff, acc_ff, num_ff;
   logic [CW-1:0]        mul_b_ff;
   logic [2:0]           res_status_ff;
   logic [PRED_BITS-1:0] res_pred_ff;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [PRED_BITS-1:0] rsp_pred_ff;
   logic [SIZE_BITS-1:0] rsp_min_ff, rsp_max_ff;

   logic       req_take, slot_free, issue, code_ok;
   logic [CW:0] div_r2;
   logic [QW-1:0] quo_ext;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign issue     = (idx_ff < count_ff);
   assign code_ok   = (rdata_ff.code_a == ca_ff) && (rdata_ff.code_b == cb_ff);
   assign div_r2    = {rem_ff, num_ff[NW-1]};
   assign quo_ext   = QW'(num_ff);

   // table memory, written on append and read during scans
   always_ff @(posedge clock) begin
      if (req_take && req_action == ACT_APPEND && count_ff != CNTW'(TABLE_DEPTH)) begin
         mem[count_ff[AW-1:0]] <= '{req_tile_size, req_trans_a, req_trans_b, req_entry_time};
      end
      rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   // sequencer state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = (req_action == ACT_QUERY && count_ff != '0) ? S_SCAN1 : S_FIN;
            end
         end
         S_SCAN1: begin
            if (pend_ff && rdata_ff.size == q_ff && code_ok) state_in = S_FIN;
            else if (!issue && !pend_ff) state_in = (near_ff != '0) ? S_SCAN2 : S_FIN;
         end
         S_SCAN2: begin
            if (pend_ff && rdata_ff.size == near_ff && code_ok) state_in = S_MUL;
            else if (!issue && !pend_ff) state_in = S_FIN;
         end
         S_MUL: begin
            if (mul_b_ff == '0 && mstep_ff == 3'd4) state_in = S_DIV;
         end
         S_DIV: begin
            if (dcnt_ff == '0) state_in = S_FIN;
         end
         S_FIN: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         // table count and size bounds
         if (req_take && req_action == ACT_CLEAR) begin
            count_ff <= '0;
            min_ff   <= '0;
            max_ff   <= '0;
         end else if (req_take && req_action == ACT_APPEND &&
                      count_ff != CNTW'(TABLE_DEPTH)) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == '0 || req_tile_size < min_ff) min_ff <= req_tile_size;
            if (count_ff == '0 || req_tile_size > max_ff) max_ff <= req_tile_size;
         end
         // read pipeline flag
         if ((state_ff == S_SCAN1 || state_ff == S_SCAN2) && state_in == state_ff) begin
            pend_ff <= issue;
         end else begin
            pend_ff <= 1'b0;
         end
         // output register
         if (state_ff == S_FIN && slot_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            q_ff        <= req_tile_size;
            ca_ff       <= req_trans_a;
            cb_ff       <= req_trans_b;
            idx_ff      <= '0;
            near_ff     <= '0;
            nstop_ff    <= 1'b0;
            res_pred_ff <= '0;
            if (req_action == ACT_APPEND && count_ff == CNTW'(TABLE_DEPTH)) begin
               res_status_ff <= ST_FULL;
            end else if (req_action == ACT_QUERY && count_ff == '0) begin
               res_status_ff <= ST_EMPTY;
            end else begin
               res_status_ff <= ST_DONE;
            end
         end
         S_SCAN1: begin
            pend_idx_ff <= idx_ff;
            if (issue) idx_ff <= idx_ff + 1'b1;
            if (pend_ff) begin
               // exact hit, else track the nearest size not above the query (the first entry's size if it is above)
               if (rdata_ff.size == q_ff && code_ok) begin
                  res_status_ff <= ST_HIT;
                  res_pred_ff   <= PRED_BITS'(rdata_ff.etime);
               end else if (pend_idx_ff == '0 && q_ff < rdata_ff.size) begin
                  near_ff  <= rdata_ff.size;
                  nstop_ff <= 1'b1;
               end else if (!nstop_ff) begin
                  if (rdata_ff.size > q_ff) begin
                     nstop_ff <= 1'b1;
                  end else begin
                     near_ff <= rdata_ff.size;
                     if (rdata_ff.size == q_ff) nstop_ff <= 1'b1;
                  end
               end
            end
            if (!issue && !pend_ff) begin
               idx_ff        <= '0;
               res_status_ff <= ST_NOTFOUND;
            end
         end
         S_SCAN2: begin
            if (issue) idx_ff <= idx_ff + 1'b1;
            // first entry with the nearest size and matching codes
            if (pend_ff && rdata_ff.size == near_ff && code_ok) begin
               t_ff     <= rdata_ff.etime;
               mstep_ff <= '0;
               mul_a_ff <= NW'(q_ff);
               mul_b_ff <= CW'(q_ff);
               acc_ff   <= '0;
            end
         end
         S_MUL: begin
            // shift-add multiplier, chained through the cube and scale products
            if (mul_b_ff != '0) begin
               if (mul_b_ff[0]) acc_ff <= acc_ff + mul_a_ff;
               mul_a_ff <= {mul_a_ff[NW-2:0], 1'b0};
               mul_b_ff <= mul_b_ff >> 1;
            end else begin
               mstep_ff <= mstep_ff + 3'd1;
               acc_ff   <= '0;
               case (mstep_ff)
                  3'd0: begin
                     mul_a_ff <= acc_ff;
                     mul_b_ff <= CW'(q_ff);
                  end
                  3'd1: begin
                     n_ff     <= CW'(acc_ff);
                     mul_a_ff <= NW'(near_ff);
                     mul_b_ff <= CW'(near_ff);
                  end
                  3'd2: begin
                     mul_a_ff <= acc_ff;
                     mul_b_ff <= CW'(near_ff);
                  end
                  3'd3: begin
                     d_ff     <= CW'(acc_ff);
                     mul_a_ff <= NW'(t_ff);
                     mul_b_ff <= n_ff;
                  end
                  default: begin
                     num_ff  <= acc_ff;
                     rem_ff  <= '0;
                     dcnt_ff <= DCW'(NW);
                  end
               endcase
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (dcnt_ff != '0) begin
               dcnt_ff <= dcnt_ff - 1'b1;
               if (div_r2 >= {1'b0, d_ff}) begin
                  rem_ff <= CW'(div_r2 - {1'b0, d_ff});
                  num_ff <= {num_ff[NW-2:0], 1'b1};
               end else begin
                  rem_ff <= div_r2[CW-1:0];
                  num_ff <= {num_ff[NW-2:0], 1'b0};
               end
            end else begin
               res_status_ff <= ST_SCALED;
               res_pred_ff   <= (quo_ext > QW'({PRED_BITS{1'b1}})) ? {PRED_BITS{1'b1}}
                                                                   : quo_ext[PRED_BITS-1:0];
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_pred_ff   <= res_pred_ff;
               rsp_min_ff    <= min_ff;
               rsp_max_ff    <= max_ff;
            end
         end
         default: begin
            idx_ff <= '0;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_predicted_time = rsp_pred_ff;
   assign rsp_smallest_size  = rsp_min_ff;
   assign rsp_largest_size   = rsp_max_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (d_ff != '0))
      else $error("divide by zero cube");

   a_pred_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_HIT && rsp_status_ff != ST_SCALED)
         |-> (rsp_pred_ff == '0))
      else $error("prediction set without hit or scale");

endmodule
